FILE: rtl/spectrum_bin_average_colormap_assert.svh
// Assertion macros used by the checker file.
`ifndef SPECTRUM_BIN_AVERAGE_COLORMAP_ASSERT_SVH
`define SPECTRUM_BIN_AVERAGE_COLORMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sbac_pkg.sv
package sbac_pkg;

    localparam int MAX_COLUMNS       = 4096;
    localparam int GAMMA_TABLE_DEPTH = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int GSIZE_W    = 7;
    localparam int CHAN_W     = 8;
    localparam int COLUMN_W   = 12;
    localparam int COL_CNT_W  = $clog2(MAX_COLUMNS);
    localparam int SUM_W      = 23;
    localparam int MEAN_W     = 17;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;
    localparam int GAMMA_W    = 17;
    localparam int GAMMA_AW   = $clog2(GAMMA_TABLE_DEPTH);
    localparam int GAMMA_TOP  = GAMMA_TABLE_DEPTH - 1;
    localparam int IDX_W      = FRAC_W + GAMMA_AW + 1;

    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = 3 * CHAN_W + COLUMN_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_QW      = 22;
    localparam int DIV_DW      = 16;
    localparam int DIV_CW      = 5;
    localparam int MEAN_STEPS  = DIV_QW;
    localparam int FRAC_STEPS  = FRAC_SHIFT;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] GAMMA_DEN = 64'(GAMMA_TOP) << 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL  = 2'd0,
        CFG_MAX_LEVEL  = 2'd1,
        CFG_GROUP_SIZE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] rem;
        logic [DIV_QW-1:0] quo;
        logic [DIV_DW-1:0] divisor;
        logic [DIV_CW-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef logic [GAMMA_W-1:0] gamma_tab_t [GAMMA_TABLE_DEPTH];
    typedef logic [63:0] root_chain_t [21];

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        int j;
        v = value;
        res = '0;
        bitv = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (j = 0; j < 32; j++) begin
            if (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q20(input logic [31:0] n);
        int k;
        int j;
        logic [63:0] m;
        logic [63:0] frac;
        k = 0;
        frac = '0;
        for (j = 0; j < 31; j++) begin
            if (k < 31 && (n >> (k + 1)) != 0) k++;
        end
        m = 64'(n) << (30 - k);
        for (j = 0; j < 20; j++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k) << 20) | frac;
    endfunction

    function automatic logic [63:0] exp2neg_q30(input logic [63:0] a,
                                                input root_chain_t chain);
        logic [63:0] whole;
        logic [63:0] p;
        int k;
        whole = a >> 20;
        p = ONE_Q30;
        for (k = 1; k <= 20; k++) begin
            if (a[20-k]) p = (p * chain[k]) >> 30;
        end
        if (whole >= 64'd31) return '0;
        return p >> whole;
    endfunction

    function automatic gamma_tab_t build_gamma_table();
        gamma_tab_t  tab;
        root_chain_t chain;
        logic [63:0] log_top;
        logic [63:0] log_gap;
        logic [63:0] p;
        logic [63:0] num;
        int i;
        int k;
        chain[0] = ONE_Q30;
        chain[1] = isqrt64(64'd1 << 59);
        for (k = 2; k <= 20; k++) chain[k] = isqrt64(chain[k-1] << 30);
        log_top = log2_q20(32'(GAMMA_TOP));
        tab[0] = '0;
        for (i = 1; i < GAMMA_TABLE_DEPTH; i++) begin
            log_gap = log_top - log2_q20(32'(i));
            p = exp2neg_q30((log_gap + 64'd10) / 64'd20, chain);
            num = 64'(i) * p * 64'd65536;
            tab[i] = GAMMA_W'((num + GAMMA_DEN / 2) / GAMMA_DEN);
        end
        return tab;
    endfunction

endpackage

FILE: rtl/spectrum_bin_average_colormap.sv
// Channel   | Ports                     | tdata / tuser fields, low bit up
// ----------+---------------------------+-------------------------------------
// input     | s_tvalid s_tready s_tdata | power_sample[15:0]; tlast = line_end
// result    | m_tvalid m_tready m_tdata | red, green, blue, column, 4 pad bits
// config    | cfg_wr_en cfg_index       | cfg_wdata: register value
//
// A sample that closes no group leaves the block ready for the next. One that closes
// a group takes the accept, 22 divider steps for the mean, 16 for the normalized
// fraction, and the steps that take the mean, normalize, take the fraction, read
// the gamma ROM and map. An empty span or a clamped fraction skips the second division.
// Reset is synchronous, active low; control and config registers return to their reset levels.
// A stalled m_tready holds the pending pixel; the next pixel waits in the map step.
module spectrum_bin_average_colormap
    import sbac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // power_sample[15:0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // red[7:0] green[15:8] blue[23:16] column[35:24]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MDIV = 6'b000010,
        S_NORM = 6'b000100,
        S_FDIV = 6'b001000,
        S_ROM  = 6'b010000,
        S_MAP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [LEVEL_W-1:0] min_level_reg;
    logic signed [LEVEL_W-1:0] max_level_reg;
    logic [GSIZE_W-1:0]        group_size_reg;

    logic signed [SUM_W-1:0]   group_sum_reg, group_sum_next;
    logic [GSIZE_W-1:0]        group_count_reg, group_count_next;
    logic [COL_CNT_W-1:0]      column_count_reg, column_count_next;

    logic                      neg_reg, neg_next;
    logic [COL_CNT_W-1:0]      col_snap_reg, col_snap_next;
    logic signed [MEAN_W-1:0]  mean_reg, mean_next;
    logic [FRAC_W-1:0]         frac_reg, frac_next;

    logic                      out_valid_reg, out_valid_next;
    pixel_t                    out_pix_reg, out_pix_next;
    logic [COL_CNT_W-1:0]      out_col_reg, out_col_next;

    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    sum_new;
    logic [GSIZE_W-1:0]         count_new;
    logic [GSIZE_W-1:0]         gs_eff;
    logic                       close;
    logic [DIV_QW-1:0]          sum_mag;
    logic                       in_acc;
    logic signed [MEAN_W:0]     rel;
    logic signed [LEVEL_W:0]    span;
    logic [IDX_W-1:0]           idx_sum;
    logic [IDX_W-1:0]           idx_sh;
    logic [GAMMA_AW-1:0]        rom_addr;
    logic [GAMMA_W-1:0]         rom_data;
    pixel_t                     map_pix;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sbac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sbac_gamma_rom u_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .rdata (rom_data)
    );

    sbac_cmap u_cmap (
        .gval (rom_data),
        .pix  (map_pix)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), COLUMN_W'(out_col_reg),
                       out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg  <= -16'sd30720;
            max_level_reg  <= -16'sd5120;
            group_size_reg <= 7'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_LEVEL:  min_level_reg  <= cfg_wdata;
                CFG_MAX_LEVEL:  max_level_reg  <= cfg_wdata;
                CFG_GROUP_SIZE: group_size_reg <= cfg_wdata[GSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sample    = s_tdata[SAMPLE_W-1:0];
        sum_new   = group_sum_reg + SUM_W'(sample);
        count_new = group_count_reg + 1'b1;
        gs_eff    = (group_size_reg == '0) ? GSIZE_W'(1) : group_size_reg;
        close     = count_new >= gs_eff;
        sum_mag   = sum_new[SUM_W-1] ? DIV_QW'(-sum_new) : sum_new[DIV_QW-1:0];
        rel       = (MEAN_W+1)'(mean_reg) - (MEAN_W+1)'(min_level_reg);
        span      = (LEVEL_W+1)'(max_level_reg) - (LEVEL_W+1)'(min_level_reg);
        idx_sum   = IDX_W'(frac_reg) * IDX_W'(GAMMA_TOP) + IDX_W'(32768);
        idx_sh    = idx_sum >> FRAC_SHIFT;
        rom_addr  = (idx_sh > IDX_W'(GAMMA_TOP)) ? GAMMA_AW'(GAMMA_TOP)
                                                 : idx_sh[GAMMA_AW-1:0];
    end

    always_comb begin
        state_next        = state_reg;
        group_sum_next    = group_sum_reg;
        group_count_next  = group_count_reg;
        column_count_next = column_count_reg;
        neg_next          = neg_reg;
        col_snap_next     = col_snap_reg;
        mean_next         = mean_reg;
        frac_next         = frac_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_pix_next      = out_pix_reg;
        out_col_next      = out_col_reg;
        div_req           = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    group_sum_next   = sum_new;
                    group_count_next = count_new;
                    if (close) begin
                        group_sum_next    = '0;
                        group_count_next  = '0;
                        col_snap_next     = column_count_reg;
                        column_count_next = column_count_reg + 1'b1;
                        neg_next          = sum_new[SUM_W-1];
                        div_req.start     = 1'b1;
                        div_req.quo       = sum_mag;
                        div_req.divisor   = DIV_DW'(gs_eff);
                        div_req.steps     = DIV_CW'(MEAN_STEPS);
                        state_next        = S_MDIV;
                    end
                    if (s_tlast) begin
                        group_sum_next    = '0;
                        group_count_next  = '0;
                        column_count_next = '0;
                    end
                end
            end
            S_MDIV: begin
                if (div_rsp.done) begin
                    mean_next  = neg_reg ? MEAN_W'(-div_rsp.quo[MEAN_W-1:0])
                                         : div_rsp.quo[MEAN_W-1:0];
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (span <= 0 || rel <= 0) begin
                    frac_next  = '0;
                    state_next = S_ROM;
                end else if (rel >= (MEAN_W+1)'(span)) begin
                    frac_next  = FRAC_W'(1) << FRAC_SHIFT;
                    state_next = S_ROM;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.rem     = rel[DIV_DW-1:0];
                    div_req.divisor = span[DIV_DW-1:0];
                    div_req.steps   = DIV_CW'(FRAC_STEPS);
                    state_next      = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    frac_next  = FRAC_W'(div_rsp.quo[FRAC_SHIFT-1:0]);
                    state_next = S_ROM;
                end
            end
            S_ROM: begin
                state_next = S_MAP;
            end
            S_MAP: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_pix_next   = map_pix;
                    out_col_next   = col_snap_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            group_sum_reg    <= '0;
            group_count_reg  <= '0;
            column_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            group_sum_reg    <= group_sum_next;
            group_count_reg  <= group_count_next;
            column_count_reg <= column_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        col_snap_reg <= col_snap_next;
        mean_reg     <= mean_next;
        frac_reg     <= frac_next;
        out_pix_reg  <= out_pix_next;
        out_col_reg  <= out_col_next;
    end

endmodule

FILE: rtl/sbac_div.sv
module sbac_div
    import sbac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_QW-1:0] quo_reg;
    logic [DIV_DW-1:0] div_reg;

    logic [DIV_DW:0]   shifted;
    logic              qbit;
    logic [DIV_DW-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_QW-1]};
        qbit     = shifted >= {1'b0, div_reg};
        rem_next = qbit ? DIV_DW'(shifted - {1'b0, div_reg}) : shifted[DIV_DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem;
            quo_reg <= req.quo;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_QW-2:0], qbit};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: rtl/sbac_gamma_rom.sv
module sbac_gamma_rom
    import sbac_pkg::*;
(
    input  logic                aclk,
    input  logic [GAMMA_AW-1:0] addr,
    output logic [GAMMA_W-1:0]  rdata
);

    localparam gamma_tab_t GAMMA_TAB = build_gamma_table();

    logic [GAMMA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        rdata_reg <= GAMMA_TAB[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sbac_cmap.sv
module sbac_cmap
    import sbac_pkg::*;
(
    input  logic [GAMMA_W-1:0] gval,
    output pixel_t             pix
);

    localparam logic [GAMMA_W-1:0] G_BLUE_END  = 17'd8192;
    localparam logic [GAMMA_W-1:0] G_GREEN_END = 17'd24576;
    localparam logic [GAMMA_W-1:0] G_MID_LAST  = 17'd52428;
    localparam logic [GAMMA_W-1:0] G_HIGH_LAST = 17'd65535;

    function automatic logic [CHAN_W-1:0] chan(input logic signed [19:0] num,
                                               input logic half);
        logic [27:0] prod;
        logic [11:0] v;
        if (num <= 0) return '0;
        prod = 28'(num[18:0]) * 28'd255;
        v = half ? 12'(prod[27:17]) : prod[27:16];
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    logic signed [19:0] g;

    always_comb begin
        g = $signed({3'b000, gval});
        pix = '0;
        if (gval < G_BLUE_END) begin
            pix.blue = chan(20'sd4 * g + 20'sd32768, 1'b0);
        end else if (gval < G_GREEN_END) begin
            pix.green = chan(20'sd4 * (g - 20'sd8192), 1'b0);
            pix.blue  = 8'd255;
        end else if (gval <= G_MID_LAST) begin
            pix.red   = chan(20'sd4 * (g - 20'sd24576), 1'b0);
            pix.green = 8'd255;
            pix.blue  = chan(20'sd65536 - 20'sd4 * (g - 20'sd24576), 1'b0);
        end else if (gval <= G_HIGH_LAST) begin
            pix.red   = 8'd255;
            pix.green = chan(20'sd65536 - 20'sd4 * (g - 20'sd40960), 1'b0);
        end else begin
            pix.red = chan(20'sd131072 - (g - 20'sd57344), 1'b1);
        end
    end

endmodule

FILE: rtl/sbac_check.sv
`include "spectrum_bin_average_colormap_assert.svh"

module sbac_check
    import sbac_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `SBAC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "pixel changed while stalled")

    `SBAC_ASSERT_IMP(a_pixel_after_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "pixel appeared without a busy cycle before it")

    `SBAC_ASSERT_IMP(a_colormap_shape, aclk, aresetn, m_tvalid, m_tdata[7:0] == 8'd0 || m_tdata[23:16] == 8'd0 || m_tdata[15:8] == 8'd255, "pixel off the colormap")

endmodule

bind spectrum_bin_average_colormap sbac_check u_sbac_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
